// ===== design/hdt_pkg.sv =====
// ----------------------------------------------------------------------------
// hdt_pkg
// Shared types and constants for the heartbeat deadline tracker.
// ----------------------------------------------------------------------------
package hdt_pkg;

  localparam int MS_W   = 32;
  localparam int TIME_W = 64;
  localparam int SCALE_W = 20;
  localparam int DUR_W  = MS_W + SCALE_W;

  localparam logic [SCALE_W-1:0] MS_TO_NS = SCALE_W'(1000000);

  localparam logic [1:0] OP_RECV  = 2'd0;
  localparam logic [1:0] OP_PING  = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  localparam logic [1:0] ACT_WAIT         = 2'd0;
  localparam logic [1:0] ACT_PING         = 2'd1;
  localparam logic [1:0] ACT_EXPIRED      = 2'd2;
  localparam logic [1:0] ACT_RECV_EXPIRED = 2'd3;

  localparam logic [1:0] REG_PING_INTERVAL = 2'd0;
  localparam logic [1:0] REG_HB_TIMEOUT    = 2'd1;
  localparam logic [1:0] REG_RX_TIMEOUT    = 2'd2;

  // Durations already scaled to nanoseconds, plus the zero flags of the
  // millisecond settings they came from.
  typedef struct packed {
    logic [DUR_W-1:0] ping_dur;
    logic [DUR_W-1:0] hb_dur;
    logic [DUR_W-1:0] rx_dur;
    logic             ping_zero;
    logic             hb_zero;
    logic             rx_never;
  } cfg_t;

endpackage

// ===== design/hdt_cfg.sv =====
// ----------------------------------------------------------------------------
// hdt_cfg
// Configuration registers; each write is scaled to nanoseconds on the way in.
// ----------------------------------------------------------------------------
module hdt_cfg
  import hdt_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [1:0]      cfg_index,
  input  logic [MS_W-1:0] cfg_data,
  output cfg_t            cfg
);

  logic [DUR_W-1:0] scaled;
  logic             data_zero;

  // One shared multiplier serves all three registers.
  assign scaled    = DUR_W'(cfg_data) * DUR_W'(MS_TO_NS);
  assign data_zero = (cfg_data == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ping_dur  <= '0;
      cfg.hb_dur    <= '0;
      cfg.rx_dur    <= '0;
      cfg.ping_zero <= 1'b1;
      cfg.hb_zero   <= 1'b1;
      cfg.rx_never  <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PING_INTERVAL: begin
          cfg.ping_dur  <= scaled;
          cfg.ping_zero <= data_zero;
        end
        REG_HB_TIMEOUT: begin
          cfg.hb_dur  <= scaled;
          cfg.hb_zero <= data_zero;
        end
        REG_RX_TIMEOUT: begin
          cfg.rx_dur   <= scaled;
          cfg.rx_never <= data_zero;
        end
        default: begin
        end
      endcase
    end
  end

  a_zero_flags: assert property (@(posedge clk) disable iff (rst)
    (cfg.ping_zero == (cfg.ping_dur == '0)) && (cfg.hb_zero == (cfg.hb_dur == '0))
    && (cfg.rx_never == (cfg.rx_dur == '0)))
    else $error("zero flag disagrees with stored duration");

endmodule

// ===== design/hdt_core.sv =====
// ----------------------------------------------------------------------------
// hdt_core
// Deadline registers, event update, query decision and the result register.
// ----------------------------------------------------------------------------
module hdt_core
  import hdt_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  logic              stage_valid,
  input  logic [1:0]        stage_op,
  input  logic [TIME_W-1:0] stage_now,
  output logic              advance,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        action,
  output logic [TIME_W-1:0] wait_deadline
);

  logic [TIME_W-1:0] ping_due;
  logic [TIME_W-1:0] heartbeat_due;
  logic [TIME_W-1:0] receive_due;
  logic [TIME_W-1:0] ping_sum;
  logic [TIME_W-1:0] hb_sum;
  logic [TIME_W-1:0] rx_sum;
  logic [TIME_W-1:0] min_ph;
  logic [TIME_W-1:0] deadline_next;
  logic [1:0]        action_next;
  logic              out_free;
  logic              is_query;
  logic              do_step;

  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] t,
                                                input logic [DUR_W-1:0] d);
    logic [TIME_W:0] s;
    s = {1'b0, t} + (TIME_W+1)'(d);
    return s[TIME_W] ? '1 : s[TIME_W-1:0];
  endfunction

  assign out_free = !out_valid || !out_stall;
  assign is_query = (stage_op == OP_QUERY);
  assign advance  = stage_valid && (!is_query || out_free);
  assign do_step  = advance;

  assign ping_sum = sat_add(stage_now, cfg.ping_dur);
  assign hb_sum   = sat_add(stage_now, cfg.hb_dur);
  // A receive timeout of zero means the deadline never comes.
  assign rx_sum   = cfg.rx_never ? '1 : sat_add(stage_now, cfg.rx_dur);

  assign min_ph = (heartbeat_due < ping_due) ? heartbeat_due : ping_due;

  always_comb begin
    action_next   = ACT_WAIT;
    deadline_next = '0;
    if (cfg.ping_zero || cfg.hb_zero) begin
      action_next = ACT_RECV_EXPIRED;
    end else if (heartbeat_due <= stage_now) begin
      action_next = ACT_EXPIRED;
    end else if (receive_due <= stage_now) begin
      action_next = ACT_RECV_EXPIRED;
    end else if (ping_due <= stage_now) begin
      action_next = ACT_PING;
    end else begin
      deadline_next = (receive_due < min_ph) ? receive_due : min_ph;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ping_due      <= '0;
      heartbeat_due <= '0;
      receive_due   <= '0;
    end else if (do_step) begin
      case (stage_op)
        OP_RECV: begin
          ping_due      <= ping_sum;
          heartbeat_due <= hb_sum;
          receive_due   <= rx_sum;
        end
        OP_PING: begin
          ping_due <= ping_sum;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (do_step && is_query) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_step && is_query) begin
      action        <= action_next;
      wait_deadline <= deadline_next;
    end
  end

  a_deadline_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (action != ACT_WAIT) |-> (wait_deadline == '0))
    else $error("nonzero deadline with a non-wait action");

  a_rearm_not_past: assert property (@(posedge clk) disable iff (rst)
    do_step && (stage_op == OP_RECV) |=>
      (ping_due >= $past(stage_now)) && (heartbeat_due >= $past(stage_now))
      && (receive_due >= $past(stage_now)))
    else $error("rearmed deadline lies before the event time");

  a_query_waits: assert property (@(posedge clk) disable iff (rst)
    stage_valid && is_query && out_valid && out_stall |-> !advance)
    else $error("query evaluated while the result register is occupied");

endmodule

// ===== design/heartbeat_deadline_tracker.sv =====
// ----------------------------------------------------------------------------
// heartbeat_deadline_tracker
// Keepalive timer holding the ping, heartbeat and receive deadlines.
// ----------------------------------------------------------------------------
// The block takes one word per clock cycle unless a query waits on the
// result register. A word is held in an input register until it advances;
// there the deadline update or the query decision (three 64-bit compares, a
// minimum and saturating adds) is made and the answer is loaded into the
// result register. Traffic and ping events give no result and never wait on
// the output side; a query waits only while the result register still holds
// an answer that has not been taken. The millisecond settings are scaled to
// nanoseconds by a single multiplier at the moment they are written, so an
// event may follow a write in the next cycle.
module heartbeat_deadline_tracker
  import hdt_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [MS_W-1:0]   cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        operation,
  input  logic [TIME_W-1:0] now_ns,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        action,
  output logic [TIME_W-1:0] wait_deadline
);

  cfg_t              cfg;
  logic              stage_valid;
  logic [1:0]        stage_op;
  logic [TIME_W-1:0] stage_now;
  logic              advance;
  logic              take;

  assign in_stall = stage_valid && !advance;
  assign take     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (take) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      stage_op  <= operation;
      stage_now <= now_ns;
    end
  end

  hdt_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  hdt_core u_core (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .stage_valid   (stage_valid),
    .stage_op      (stage_op),
    .stage_now     (stage_now),
    .advance       (advance),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .action        (action),
    .wait_deadline (wait_deadline)
  );

  a_stall_needs_word: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> stage_valid && (stage_op == OP_QUERY) && out_valid)
    else $error("input stalled without a blocked query");

endmodule
